// ===== sv/pte_pkg.sv =====
`timescale 1ns / 1ps

package pte_pkg;

  // Row geometry and arithmetic widths.
  localparam int MAX_COLUMNS = 6;
  localparam int VALUE_BITS  = 16;
  localparam int COL_BITS    = 3;
  localparam int MASK_BITS   = 6;
  localparam int TERM_BITS   = 48;
  localparam int PAIR_BITS   = 2 * VALUE_BITS;
  localparam int TRIPLE_BITS = 3 * VALUE_BITS;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BINARY_MASK  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TERM_ORDER   = 2'd2;

  // Register reset values and order codes.
  localparam logic [COL_BITS-1:0] COUNT_RESET  = 3'd6;
  localparam logic [1:0]          ORDER_RESET  = 2'd2;
  localparam logic [1:0]          ORDER_TRIPLE = 2'd3;

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCOUNT_BITS = 2;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // One completed row with the settings it is expanded under.
  typedef struct packed {
    value_t [MAX_COLUMNS-1:0] row;
    logic [COL_BITS-1:0]      count;
    logic [MASK_BITS-1:0]     mask;
    logic                     order3;
  } job_t;

  // Column count as used: zero acts as one, large values clip to the row size.
  function automatic logic [COL_BITS-1:0] eff_count(input logic [COL_BITS-1:0] c);
    logic [COL_BITS-1:0] r;
    r = c;
    if (c == '0) begin
      r = COL_BITS'(1);
    end else if (c > COL_BITS'(MAX_COLUMNS)) begin
      r = COL_BITS'(MAX_COLUMNS);
    end
    return r;
  endfunction

endpackage

// ===== sv/pte_front.sv =====
`timescale 1ns / 1ps

module pte_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  pte_pkg::value_t                      sample_value,
  input  logic                                 cfg_write,
  input  logic [pte_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [pte_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic                                 push,
  output pte_pkg::job_t                        push_job
);

  logic [pte_pkg::COL_BITS-1:0]  column_count;
  logic [pte_pkg::MASK_BITS-1:0] binary_column_mask;
  logic [1:0]                    term_order;
  logic [pte_pkg::COL_BITS-1:0]  loaded_count;
  pte_pkg::value_t               row_store [pte_pkg::MAX_COLUMNS];

  logic [pte_pkg::COL_BITS-1:0]  count_eff;
  logic [pte_pkg::COL_BITS:0]    loaded_plus;
  logic                          row_complete;
  logic                          in_range;

  // Row completion test against the effective column count.
  always_comb begin
    count_eff    = pte_pkg::eff_count(column_count);
    loaded_plus  = {1'b0, loaded_count} + (pte_pkg::COL_BITS + 1)'(1);
    row_complete = loaded_plus >= {1'b0, count_eff};
    in_range     = loaded_count < pte_pkg::COL_BITS'(pte_pkg::MAX_COLUMNS);
  end

  // Configuration registers and the load counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count       <= pte_pkg::COUNT_RESET;
      binary_column_mask <= '0;
      term_order         <= pte_pkg::ORDER_RESET;
      loaded_count       <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          pte_pkg::REG_COLUMN_COUNT: column_count <= cfg_data[pte_pkg::COL_BITS-1:0];
          pte_pkg::REG_BINARY_MASK:  binary_column_mask <= cfg_data[pte_pkg::MASK_BITS-1:0];
          pte_pkg::REG_TERM_ORDER:   term_order <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (accept) begin
        loaded_count <= row_complete ? '0 : loaded_plus[pte_pkg::COL_BITS-1:0];
      end
    end
  end

  // Row buffer, written one word per accepted sample.
  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      row_store[loaded_count] <= sample_value;
    end
  end

  // The finished row, with the last word merged in, goes to the queue.
  always_comb begin
    push = accept && row_complete;
    for (int c = 0; c < pte_pkg::MAX_COLUMNS; c++) begin
      push_job.row[c] = (pte_pkg::COL_BITS'(c) == loaded_count) ? sample_value : row_store[c];
    end
    push_job.count  = count_eff;
    push_job.mask   = binary_column_mask;
    push_job.order3 = term_order == pte_pkg::ORDER_TRIPLE;
  end

endmodule

// ===== sv/pte_queue.sv =====
`timescale 1ns / 1ps

module pte_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pte_pkg::job_t push_job,
  input  logic          pop,
  output pte_pkg::job_t head,
  output logic          not_empty,
  output logic          full
);

  pte_pkg::job_t                    slots [pte_pkg::QUEUE_DEPTH];
  logic [pte_pkg::QPTR_BITS-1:0]    wr_ptr;
  logic [pte_pkg::QPTR_BITS-1:0]    rd_ptr;
  logic [pte_pkg::QCOUNT_BITS-1:0]  count;

  assign not_empty = count != '0;
  assign full      = count == pte_pkg::QCOUNT_BITS'(pte_pkg::QUEUE_DEPTH);
  assign head      = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + pte_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + pte_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + pte_pkg::QCOUNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - pte_pkg::QCOUNT_BITS'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTH
  // The front never pushes a row into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("row pushed into a full job queue");
  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("job popped from an empty queue");
  // The fill level never passes the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pte_pkg::QCOUNT_BITS'(pte_pkg::QUEUE_DEPTH))
    else $error("job queue fill level out of range");
`endif

endmodule

// ===== sv/pte_back.sv =====
`timescale 1ns / 1ps

module pte_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              job_valid,
  input  pte_pkg::job_t                     job,
  output logic                              pop,
  output logic                              result_valid,
  output logic signed [pte_pkg::TERM_BITS-1:0] term_value,
  output logic [pte_pkg::COL_BITS-1:0]      first_column,
  output logic [pte_pkg::COL_BITS-1:0]      second_column,
  output logic [pte_pkg::COL_BITS-1:0]      third_column,
  output logic                              row_done
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]                   state;
  logic [1:0]                   state_next;
  pte_pkg::job_t                work;
  logic [pte_pkg::COL_BITS-1:0] j, k, m;
  logic [pte_pkg::COL_BITS-1:0] j_next, k_next, m_next;
  logic                         skip;
  logic                         last_tuple;
  logic                         load;

  // Stage 1: tuple indices.
  logic                         s1_valid, s1_flush, s1_order3;
  logic [pte_pkg::COL_BITS-1:0] s1_j, s1_k, s1_m;
  // Stage 2: pair product and third factor.
  logic                         s2_valid, s2_flush, s2_order3;
  logic [pte_pkg::COL_BITS-1:0] s2_j, s2_k, s2_m;
  logic signed [pte_pkg::PAIR_BITS-1:0] pair;
  pte_pkg::value_t              xm;
  // Hold stage: one term is kept back until it is known whether it ends the row.
  logic                         pend_valid;
  logic signed [pte_pkg::TERM_BITS-1:0] pend_term;
  logic [pte_pkg::COL_BITS-1:0] pend_j, pend_k, pend_m;

  logic signed [pte_pkg::TRIPLE_BITS-1:0] triple;
  logic signed [pte_pkg::TERM_BITS-1:0]   term;
  logic                                   emit;

  // Tuple walk: skip test, end test and the next index set.
  always_comb begin
    skip = (j == k) && work.mask[j];
    if (work.order3) begin
      skip = skip || ((k == m) && work.mask[k]) || ((j == m) && work.mask[j]);
    end
    last_tuple = (j + pte_pkg::COL_BITS'(1)) == work.count;
    j_next = j;
    k_next = k;
    m_next = m;
    if (work.order3 && ((m + pte_pkg::COL_BITS'(1)) != work.count)) begin
      m_next = m + pte_pkg::COL_BITS'(1);
    end else if ((k + pte_pkg::COL_BITS'(1)) != work.count) begin
      k_next = k + pte_pkg::COL_BITS'(1);
      m_next = k + pte_pkg::COL_BITS'(1);
    end else begin
      j_next = j + pte_pkg::COL_BITS'(1);
      k_next = j + pte_pkg::COL_BITS'(1);
      m_next = j + pte_pkg::COL_BITS'(1);
    end
  end

  // Sequencer: take a job, walk its tuples, then send one flush marker.
  always_comb begin
    load       = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (job_valid) begin
          load       = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_tuple) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (job_valid) begin
          load       = 1'b1;
          state_next = ST_RUN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    pop = load;
  end

  // Second multiplication and the term as it leaves.
  always_comb begin
    triple = pair * xm;
    term   = s2_order3 ? pte_pkg::TERM_BITS'(triple) : pte_pkg::TERM_BITS'(pair);
    emit   = (s2_valid || s2_flush) && pend_valid;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      s1_valid     <= 1'b0;
      s1_flush     <= 1'b0;
      s2_valid     <= 1'b0;
      s2_flush     <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      s1_valid     <= (state == ST_RUN) && !skip;
      s1_flush     <= state == ST_FLUSH;
      s2_valid     <= s1_valid;
      s2_flush     <= s1_flush;
      if (s2_valid) begin
        pend_valid <= 1'b1;
      end else if (s2_flush) begin
        pend_valid <= 1'b0;
      end
      result_valid <= emit;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (load) begin
      work <= job;
      j    <= '0;
      k    <= '0;
      m    <= '0;
    end else if (state == ST_RUN) begin
      j <= j_next;
      k <= k_next;
      m <= m_next;
    end
    s1_j      <= j;
    s1_k      <= k;
    s1_m      <= m;
    s1_order3 <= work.order3;
    pair      <= $signed(work.row[s1_j]) * $signed(work.row[s1_k]);
    xm        <= $signed(work.row[s1_m]);
    s2_j      <= s1_j;
    s2_k      <= s1_k;
    s2_m      <= s1_m;
    s2_order3 <= s1_order3;
    if (s2_valid) begin
      pend_term <= term;
      pend_j    <= s2_j;
      pend_k    <= s2_k;
      pend_m    <= s2_m;
    end
    if (emit) begin
      term_value    <= pend_term;
      first_column  <= pend_j;
      second_column <= pend_k;
      third_column  <= pend_m;
      row_done      <= s2_flush;
    end
  end

`ifndef SYNTH
  // A tuple and a flush marker never share a stage.
  a_stage_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s2_valid && s2_flush))
    else $error("term and flush marker in the same stage");
  // The end-of-row word leaves the hold stage empty.
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (result_valid && row_done) |-> !pend_valid)
    else $error("term still held after the row's last word");
  // A new job is never taken while a row is being walked.
  a_no_pop_in_run: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state != ST_RUN))
    else $error("job taken in the middle of a row");
`endif

endmodule

// ===== sv/polynomial_term_expander.sv =====
`timescale 1ns / 1ps
// Path: a row's last word goes through the job queue to the back end, whose tuple walk feeds
// stage 1, stage 2 and the hold stage before the output registers; skipped tuples delay the
// next term. Throughput: one word per cycle while busy is low; the walk steps through every
// tuple (p(p+1)/2 for order 2, p(p+1)(p+2)/6 for order 3) and sends one flush marker per row;
// busy is high while the two-row queue is full and during reset. Results never wait, as the
// receiver cannot stall. Synchronous reset clears control state and sets six columns, no
// mask, order 2.

module polynomial_term_expander (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [pte_pkg::VALUE_BITS-1:0] sample_value,
  input  logic                                cfg_write,
  input  logic [pte_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [pte_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                result_valid,
  output logic signed [pte_pkg::TERM_BITS-1:0] term_value,
  output logic [pte_pkg::COL_BITS-1:0]        first_column,
  output logic [pte_pkg::COL_BITS-1:0]        second_column,
  output logic [pte_pkg::COL_BITS-1:0]        third_column,
  output logic                                row_done
);

  logic          accept;
  logic          push;
  logic          pop;
  logic          full;
  logic          not_empty;
  pte_pkg::job_t push_job;
  pte_pkg::job_t head;

  // A word is taken while the queue can still hold a finished row and reset is low.
  assign busy   = full || rst;
  assign accept = start && !busy;

  pte_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sample_value (sample_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .push         (push),
    .push_job     (push_job)
  );

  pte_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  pte_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (not_empty),
    .job           (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .term_value    (term_value),
    .first_column  (first_column),
    .second_column (second_column),
    .third_column  (third_column),
    .row_done      (row_done)
  );

endmodule

// ===== verif/polynomial_term_expander_test.sv =====
`timescale 1ns / 1ps

module polynomial_term_expander_test;
  import pte_pkg::*;

  localparam int SETTLE_CYCLES = 40;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
  localparam logic [1:0] ORDER_PAIR     = ORDER_RESET;
  localparam logic [1:0] ORDER_SPARE_LO = 2'd0;
  localparam logic [1:0] ORDER_SPARE_HI = 2'd1;
  localparam value_t MOST_POS = 16'sh7FFF;
  localparam value_t MOST_NEG = 16'sh8000;

  // One expected monomial term.
  typedef struct {
    logic signed [TERM_BITS-1:0] product;
    logic [COL_BITS-1:0]         col_a;
    logic [COL_BITS-1:0]         col_b;
    logic [COL_BITS-1:0]         col_c;
    logic                        last;
  } term_t;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  value_t                      sample_value;
  logic                        cfg_write;
  logic [CFG_INDEX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]    cfg_data;
  logic                        result_valid;
  logic signed [TERM_BITS-1:0] term_value;
  logic [COL_BITS-1:0]         first_column;
  logic [COL_BITS-1:0]         second_column;
  logic [COL_BITS-1:0]         third_column;
  logic                        row_done;

  // Shadow of the row buffer and the registers.
  value_t               row_vals [MAX_COLUMNS];
  int                   words_in_row;
  logic [COL_BITS-1:0]  cols_reg;
  logic [MASK_BITS-1:0] mask_reg;
  logic [1:0]           order_reg;

  term_t terms_due[$];
  int    idle_pct;
  int    words_sent;
  int    rows_expanded;
  int    terms_checked;
  int    cfg_writes;
  int    mismatches;

  polynomial_term_expander u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .sample_value (sample_value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .term_value   (term_value),
    .first_column (first_column),
    .second_column(second_column),
    .third_column (third_column),
    .row_done     (row_done)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Column count as the block uses it.
  function automatic int active_columns();
    int n;
    n = int'(cols_reg);
    if (n == 0) n = 1;
    if (n > MAX_COLUMNS) n = MAX_COLUMNS;
    return n;
  endfunction

  function automatic void queue_term(logic signed [63:0] prod, int a, int b, int c);
    term_t t;
    t.product = prod[TERM_BITS-1:0];
    t.col_a   = a[COL_BITS-1:0];
    t.col_b   = b[COL_BITS-1:0];
    t.col_c   = c[COL_BITS-1:0];
    t.last    = 1'b0;
    terms_due.push_back(t);
  endfunction

  // Store one accepted word; on the last word of a row, list every term it yields.
  function automatic void absorb_word(value_t v);
    int p;
    int idx;
    int before_cnt;
    logic signed [63:0] pair;
    p = active_columns();
    idx = words_in_row;
    if (idx < MAX_COLUMNS) row_vals[idx] = v;
    words_in_row = (idx + 1) % 8;
    if (idx + 1 < p) return;
    words_in_row = 0;
    rows_expanded++;
    before_cnt = terms_due.size();
    for (int j = 0; j < p; j++) begin
      for (int k = j; k < p; k++) begin
        if (j == k && mask_reg[j]) continue;
        pair = longint'(row_vals[j]) * longint'(row_vals[k]);
        if (order_reg != ORDER_TRIPLE) begin
          queue_term(pair, j, k, k);
          continue;
        end
        for (int m = k; m < p; m++) begin
          // A binary column never appears twice in one term.
          if (k == m && mask_reg[k]) continue;
          if (j == m && mask_reg[j]) continue;
          queue_term(pair * longint'(row_vals[m]), j, k, m);
        end
      end
    end
    if (terms_due.size() > before_cnt) terms_due[terms_due.size() - 1].last = 1'b1;
  endfunction

  // Full-range values half the time; otherwise the extremes, zero or minus one.
  function automatic value_t random_value();
    case ($urandom_range(7))
      0: return MOST_POS;
      1: return MOST_NEG;
      2: return value_t'(0);
      3: return value_t'(-1);
      default: return value_t'($urandom);
    endcase
  endfunction

  // Offer one word, after a random idle stretch, and wait until it is taken.
  task automatic send_word(input value_t v);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    sample_value <= v;
    do @(posedge clk); while (busy);
    absorb_word(v);
    words_sent++;
  endtask

  // Send words until the current row completes.
  task automatic finish_row();
    do send_word(random_value()); while (words_in_row != 0);
  endtask

  // Stop offering words and let every expected term come out, then give a row
  // with no terms time to finish its walk.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (terms_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_COLUMN_COUNT: cols_reg  = data[COL_BITS-1:0];
      REG_BINARY_MASK:  mask_reg  = data[MASK_BITS-1:0];
      REG_TERM_ORDER:   order_reg = data[1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic configure(input int count, input logic [MASK_BITS-1:0] mask,
                           input logic [1:0] order);
    drain();
    write_reg(REG_COLUMN_COUNT, CFG_DATA_BITS'(count));
    write_reg(REG_BINARY_MASK, CFG_DATA_BITS'(mask));
    write_reg(REG_TERM_ORDER, CFG_DATA_BITS'(order));
  endtask

  // Reset settings: six columns, pairwise, no mask; extremes and alternating bits.
  task automatic test_default_row();
    send_word(MOST_POS);
    send_word(MOST_NEG);
    send_word(value_t'(0));
    send_word(value_t'(-1));
    send_word(value_t'(16'h5555));
    send_word(value_t'(16'hAAAA));
  endtask

  // A count of seven acts as six; order 3 gives the largest set of terms.
  task automatic test_full_triple();
    configure(7, '0, ORDER_TRIPLE);
    send_word(MOST_NEG);
    send_word(MOST_NEG);
    send_word(MOST_POS);
    send_word(value_t'(16'h2AAA));
    send_word(value_t'(-16'sh1234));
    send_word(value_t'(1));
  endtask

  // A count of zero acts as one column.
  task automatic test_single_column();
    configure(0, '0, ORDER_PAIR);
    send_word(MOST_NEG);
  endtask

  // Order codes other than 3 act as pairwise; the spare register index does nothing.
  task automatic test_spare_codes();
    configure(2, 6'b000010, ORDER_SPARE_LO);
    send_word(value_t'(16'h1000));
    send_word(value_t'(-16'sh0800));
    drain();
    write_reg(REG_TERM_ORDER, CFG_DATA_BITS'(ORDER_SPARE_HI));
    write_reg(REG_SPARE, 6'h3F);
    send_word(MOST_POS);
    send_word(value_t'(3));
  endtask

  // A row whose only term is skipped, then mask bits above the count.
  task automatic test_empty_and_high_mask();
    configure(1, 6'b000001, ORDER_PAIR);
    send_word(value_t'(16'h1234));
    configure(2, 6'b111100, ORDER_TRIPLE);
    send_word(value_t'(-16'sh4000));
    send_word(value_t'(16'h0FFF));
  endtask

  // Lower the count below the words already loaded: the next word ends the row.
  task automatic test_count_lowered();
    configure(6, '0, ORDER_TRIPLE);
    repeat (4) send_word(random_value());
    drain();
    write_reg(REG_COLUMN_COUNT, CFG_DATA_BITS'(2));
    send_word(random_value());
  endtask

  // Random register writes while idle, including the spare index.
  task automatic reconfigure_random();
    logic [CFG_INDEX_BITS-1:0] idx;
    drain();
    repeat ($urandom_range(1, 3)) begin
      idx = CFG_INDEX_BITS'($urandom_range(3));
      case (idx)
        REG_COLUMN_COUNT: write_reg(idx, CFG_DATA_BITS'($urandom_range(7)));
        REG_TERM_ORDER:   write_reg(idx, CFG_DATA_BITS'($urandom_range(3)));
        default:          write_reg(idx, CFG_DATA_BITS'($urandom_range(63)));
      endcase
    end
  endtask

  // Mostly whole rows, with partial rows and register changes in between.
  task automatic test_random_traffic(input int pct, input int words);
    int target;
    int pick;
    int remaining;
    idle_pct = pct;
    target = words_sent + words;
    while (words_sent < target) begin
      pick = $urandom_range(99);
      remaining = active_columns() - words_in_row;
      if (pick < 10) begin
        reconfigure_random();
      end else if (pick < 18 && remaining > 1) begin
        repeat ($urandom_range(1, remaining - 1)) send_word(random_value());
      end else begin
        finish_row();
      end
    end
  endtask

  // Compare every result word with the oldest expected term.
  always @(posedge clk) begin : check_terms
    term_t due;
    if (!rst && result_valid) begin
      if (terms_due.size() == 0) begin
        $error("unexpected term: value %0d columns %0d %0d %0d", term_value,
               first_column, second_column, third_column);
        mismatches++;
      end else begin
        due = terms_due.pop_front();
        if (term_value !== due.product) begin
          $error("term_value: expected %0d, got %0d", due.product, term_value);
          mismatches++;
        end
        if (first_column !== due.col_a) begin
          $error("first_column: expected %0d, got %0d", due.col_a, first_column);
          mismatches++;
        end
        if (second_column !== due.col_b) begin
          $error("second_column: expected %0d, got %0d", due.col_b, second_column);
          mismatches++;
        end
        if (third_column !== due.col_c) begin
          $error("third_column: expected %0d, got %0d", due.col_c, third_column);
          mismatches++;
        end
        if (row_done !== due.last) begin
          $error("row_done: expected %0d, got %0d", due.last, row_done);
          mismatches++;
        end
        terms_checked++;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    sample_value = '0;
    cfg_write    = 1'b0;
    cfg_index    = REG_COLUMN_COUNT;
    cfg_data     = '0;
    for (int i = 0; i < MAX_COLUMNS; i++) row_vals[i] = '0;
    words_in_row  = 0;
    cols_reg      = COUNT_RESET;
    mask_reg      = '0;
    order_reg     = ORDER_RESET;
    idle_pct      = 0;
    words_sent    = 0;
    rows_expanded = 0;
    terms_checked = 0;
    cfg_writes    = 0;
    mismatches    = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_row();
    test_full_triple();
    test_single_column();
    test_spare_codes();
    test_empty_and_high_mask();
    test_count_lowered();
    test_random_traffic(0, 130);
    test_random_traffic(71, 130);
    test_random_traffic(18, 130);
    drain();

    $display("Sent %0d words in %0d rows, checked %0d terms, made %0d register writes,",
             words_sent, rows_expanded, terms_checked, cfg_writes);
    $display("over orders 2 and 3, counts 0 to 7, random masks and idle sender phases.");
    if (mismatches == 0) begin
      $display("[polynomial_term_expander] OK");
    end else begin
      $display("[polynomial_term_expander] ERROR");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2000000;
    $error("run limit reached with %0d terms outstanding", terms_due.size());
    $display("[polynomial_term_expander] ERROR");
    $finish;
  end

endmodule
